/* rtl/met_pkg.sv */
// shared types, constants and helpers for the escape-time evaluator
// no dependencies; used by every module under rtl
`default_nettype none

package met_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_ROWS    = 4096;
    localparam int FRAC_BITS   = 44;

    localparam int VAL_W   = 48;
    localparam int SQ_W    = 51;
    localparam int ITER_W  = 24;
    localparam int COORD_W = 12;
    localparam int STEP_W  = 47;
    localparam int TAG_W   = 3;
    localparam int WIDE_W  = 61;

    // register indexes of the write port
    localparam logic [2:0] REG_MAX_ITER  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_RE = 3'd1;
    localparam logic [2:0] REG_ORIGIN_IM = 3'd2;
    localparam logic [2:0] REG_STEP_RE   = 3'd3;
    localparam logic [2:0] REG_STEP_IM   = 3'd4;

    localparam logic [ITER_W-1:0] MAX_ITER_RST = 24'd10000;
    localparam logic [VAL_W-1:0]  ORIGIN_RST   = 48'hE000_0000_0000;
    localparam logic [STEP_W-1:0] STEP_RST     = 47'h0004_0000_0000;

    // |z|^2 bound of four
    localparam logic [SQ_W:0] ESC_LIMIT = 52'(4) << FRAC_BITS;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [SQ_W-1:0] sq_t;

    typedef struct packed {
        logic               valid;
        logic               done;
        logic [TAG_W-1:0]   tag;
        logic [ITER_W-1:0]  count;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        val_t               c_re;
        val_t               c_im;
    } ctx_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        val_t               c_re;
        val_t               c_im;
    } ins_t;

    typedef struct packed {
        logic [ITER_W-1:0]  count;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } ret_t;

    function automatic val_t sat_val(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}));
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            return val_t'(hi);
        end else if (v < lo) begin
            return val_t'(lo);
        end
        return val_t'(v);
    endfunction

    function automatic logic [VAL_W-1:0] mag(input val_t v);
        return v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
    endfunction

    function automatic logic signed [WIDE_W-1:0] sext(input val_t v);
        return WIDE_W'(v);
    endfunction

endpackage

`default_nettype wire

/* rtl/met_coord.sv */
// maps pixel coordinates to the point c, two register stages
// depends on met_pkg
`default_nettype none

module met_coord (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [met_pkg::COORD_W-1:0] in_col,
    input  wire logic [met_pkg::COORD_W-1:0] in_row,
    input  wire met_pkg::val_t               origin_re,
    input  wire met_pkg::val_t               origin_im,
    input  wire logic [met_pkg::STEP_W-1:0]  step_re,
    input  wire logic [met_pkg::STEP_W-1:0]  step_im,
    output logic                             ins_valid,
    output met_pkg::ins_t                    ins_word,
    input  wire logic                        ins_ready
);

    localparam int PROD_W = met_pkg::COORD_W + met_pkg::STEP_W;

    logic                        m1_valid_reg;
    logic [met_pkg::COORD_W-1:0] m1_col_reg, m1_row_reg;
    logic [PROD_W-1:0]           m1_pre_reg, m1_pim_reg;
    logic                        m2_valid_reg;
    met_pkg::ins_t               m2_word_reg;

    logic [met_pkg::COORD_W-1:0] ecol, erow;
    logic                        m2_adv;

    assign m2_adv    = !m2_valid_reg || ins_ready;
    assign in_ready  = !m1_valid_reg || m2_adv;
    assign ins_valid = m2_valid_reg;
    assign ins_word  = m2_word_reg;

    // clamp out-of-range coordinates to the last column or row
    always_comb begin
        ecol = (32'(in_col) >= met_pkg::MAX_COLUMNS) ?
               met_pkg::COORD_W'(met_pkg::MAX_COLUMNS - 1) : in_col;
        erow = (32'(in_row) >= met_pkg::MAX_ROWS) ?
               met_pkg::COORD_W'(met_pkg::MAX_ROWS - 1) : in_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                m1_valid_reg <= in_valid;
            end
            if (m2_adv) begin
                m2_valid_reg <= m1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            m1_col_reg <= in_col;
            m1_row_reg <= in_row;
            m1_pre_reg <= PROD_W'(ecol) * PROD_W'(step_re);
            m1_pim_reg <= PROD_W'(erow) * PROD_W'(step_im);
        end
        if (m2_adv && m1_valid_reg) begin
            m2_word_reg.col  <= m1_col_reg;
            m2_word_reg.row  <= m1_row_reg;
            m2_word_reg.c_re <= met_pkg::sat_val(met_pkg::sext(origin_re)
                                + met_pkg::WIDE_W'(m1_pre_reg));
            m2_word_reg.c_im <= met_pkg::sat_val(met_pkg::sext(origin_im)
                                + met_pkg::WIDE_W'(m1_pim_reg));
        end
    end

endmodule

`default_nettype wire

/* rtl/met_iter_ring.sv */
// six-stage recirculating iteration ring with in-order retirement
// depends on met_pkg
`default_nettype none

module met_iter_ring (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [met_pkg::ITER_W-1:0] max_iterations,
    input  wire logic                       ins_valid,
    input  wire met_pkg::ins_t              ins_word,
    output logic                            ins_ready,
    output logic                            ret_valid,
    output met_pkg::ret_t                   ret_word,
    input  wire logic                       ret_ready
);

    localparam int PW = 2 * met_pkg::VAL_W;
    localparam int QW = met_pkg::SQ_W + 1;
    localparam logic [PW-1:0] LOW_MASK = (PW'(1) << (met_pkg::FRAC_BITS - 1)) - PW'(1);

    typedef struct packed {
        met_pkg::ctx_t ctx;
        met_pkg::val_t x;
        met_pkg::val_t y;
        met_pkg::sq_t  xsq;
        met_pkg::sq_t  ysq;
    } slot_t;

    typedef struct packed {
        met_pkg::ctx_t ctx;
        logic [47:0]   pp0, pp1, pp2, pp3;
        logic          neg;
        met_pkg::val_t xn;
    } st1_t;

    typedef struct packed {
        met_pkg::ctx_t ctx;
        logic [QW-1:0] q;
        logic          drop;
        logic          neg;
        met_pkg::val_t xn;
        logic [47:0]   sq0, sq1, sq2;
    } st2_t;

    typedef struct packed {
        met_pkg::ctx_t ctx;
        met_pkg::val_t xn;
        met_pkg::val_t yn;
        met_pkg::sq_t  xsq;
    } st3_t;

    typedef struct packed {
        met_pkg::ctx_t ctx;
        met_pkg::val_t xn;
        met_pkg::val_t yn;
        met_pkg::sq_t  xsq;
        logic [47:0]   sq0, sq1, sq2;
    } st4_t;

    typedef struct packed {
        met_pkg::ctx_t ctx;
        met_pkg::val_t xn;
        met_pkg::val_t yn;
        met_pkg::sq_t  xsq;
        met_pkg::sq_t  ysq;
    } st5_t;

    st1_t  s1_reg, s1_next;
    st2_t  s2_reg, s2_next;
    st3_t  s3_reg, s3_next;
    st4_t  s4_reg, s4_next;
    st5_t  s5_reg, s5_next;
    slot_t s6_reg, s6_next;
    slot_t entry;

    logic [met_pkg::TAG_W-1:0] ins_seq_reg, ins_seq_next;
    logic [met_pkg::TAG_W-1:0] ret_seq_reg, ret_seq_next;
    logic                      retire;

    // entry point: retire the oldest finished pixel, fill a free slot
    always_comb begin
        ret_valid = s6_reg.ctx.valid && s6_reg.ctx.done && (s6_reg.ctx.tag == ret_seq_reg);
        retire    = ret_valid && ret_ready;
        ins_ready = !s6_reg.ctx.valid || retire;
        ret_word.count = s6_reg.ctx.count;
        ret_word.col   = s6_reg.ctx.col;
        ret_word.row   = s6_reg.ctx.row;

        entry        = s6_reg;
        ins_seq_next = ins_seq_reg;
        ret_seq_next = retire ? ret_seq_reg + 1'b1 : ret_seq_reg;
        if (retire) begin
            entry.ctx.valid = 1'b0;
        end
        if (ins_valid && ins_ready) begin
            entry.ctx.valid = 1'b1;
            entry.ctx.done  = (max_iterations == '0);
            entry.ctx.tag   = ins_seq_reg;
            entry.ctx.count = '0;
            entry.ctx.col   = ins_word.col;
            entry.ctx.row   = ins_word.row;
            entry.ctx.c_re  = ins_word.c_re;
            entry.ctx.c_im  = ins_word.c_im;
            entry.x         = '0;
            entry.y         = '0;
            entry.xsq       = '0;
            entry.ysq       = '0;
            ins_seq_next    = ins_seq_reg + 1'b1;
        end
    end

    // stage 1: partials of x*y, new real part from the old squares
    always_comb begin
        logic [47:0] ax, ay;
        ax = met_pkg::mag(entry.x);
        ay = met_pkg::mag(entry.y);
        s1_next.ctx = entry.ctx;
        s1_next.pp0 = 48'(ax[23:0]) * 48'(ay[23:0]);
        s1_next.pp1 = 48'(ax[23:0]) * 48'(ay[47:24]);
        s1_next.pp2 = 48'(ax[47:24]) * 48'(ay[23:0]);
        s1_next.pp3 = 48'(ax[47:24]) * 48'(ay[47:24]);
        s1_next.neg = entry.x[47] ^ entry.y[47];
        s1_next.xn  = met_pkg::sat_val(met_pkg::WIDE_W'(entry.xsq)
                      - met_pkg::WIDE_W'(entry.ysq) + met_pkg::sext(entry.ctx.c_re));
    end

    // stage 2: 2xy scaled down, partials of the new x squared
    always_comb begin
        logic [PW-1:0] p;
        logic [47:0]   axn;
        p = PW'(s1_reg.pp0) + (PW'(s1_reg.pp1) << 24) + (PW'(s1_reg.pp2) << 24)
            + (PW'(s1_reg.pp3) << 48);
        axn = met_pkg::mag(s1_reg.xn);
        s2_next.ctx  = s1_reg.ctx;
        s2_next.q    = QW'(p >> (met_pkg::FRAC_BITS - 1));
        s2_next.drop = |(p & LOW_MASK);
        s2_next.neg  = s1_reg.neg;
        s2_next.xn   = s1_reg.xn;
        s2_next.sq0  = 48'(axn[23:0]) * 48'(axn[23:0]);
        s2_next.sq1  = 48'(axn[23:0]) * 48'(axn[47:24]);
        s2_next.sq2  = 48'(axn[47:24]) * 48'(axn[47:24]);
    end

    // stage 3: new imaginary part (floor for negative products), x squared
    always_comb begin
        logic [met_pkg::WIDE_W-1:0] qe;
        logic [PW-1:0]              xs;
        qe = met_pkg::WIDE_W'(s2_reg.q);
        xs = PW'(s2_reg.sq0) + (PW'(s2_reg.sq1) << 25) + (PW'(s2_reg.sq2) << 48);
        s3_next.ctx = s2_reg.ctx;
        s3_next.xn  = s2_reg.xn;
        s3_next.yn  = met_pkg::sat_val(met_pkg::sext(s2_reg.ctx.c_im)
                      + signed'(s2_reg.neg ? ~qe : qe)
                      + met_pkg::WIDE_W'(s2_reg.neg && !s2_reg.drop));
        s3_next.xsq = met_pkg::SQ_W'(xs >> met_pkg::FRAC_BITS);
    end

    // stage 4: partials of the new y squared
    always_comb begin
        logic [47:0] ayn;
        ayn = met_pkg::mag(s3_reg.yn);
        s4_next.ctx = s3_reg.ctx;
        s4_next.xn  = s3_reg.xn;
        s4_next.yn  = s3_reg.yn;
        s4_next.xsq = s3_reg.xsq;
        s4_next.sq0 = 48'(ayn[23:0]) * 48'(ayn[23:0]);
        s4_next.sq1 = 48'(ayn[23:0]) * 48'(ayn[47:24]);
        s4_next.sq2 = 48'(ayn[47:24]) * 48'(ayn[47:24]);
    end

    // stage 5: y squared
    always_comb begin
        logic [PW-1:0] ys;
        ys = PW'(s4_reg.sq0) + (PW'(s4_reg.sq1) << 25) + (PW'(s4_reg.sq2) << 48);
        s5_next.ctx = s4_reg.ctx;
        s5_next.xn  = s4_reg.xn;
        s5_next.yn  = s4_reg.yn;
        s5_next.xsq = s4_reg.xsq;
        s5_next.ysq = met_pkg::SQ_W'(ys >> met_pkg::FRAC_BITS);
    end

    // stage 6: escape test and count; finished pixels pass unchanged
    always_comb begin
        logic [met_pkg::SQ_W:0]    len;
        logic [met_pkg::ITER_W-1:0] cnt;
        len = (met_pkg::SQ_W + 1)'(s5_reg.xsq) + (met_pkg::SQ_W + 1)'(s5_reg.ysq);
        cnt = s5_reg.ctx.count + 1'b1;
        s6_next.ctx = s5_reg.ctx;
        s6_next.x   = s5_reg.xn;
        s6_next.y   = s5_reg.yn;
        s6_next.xsq = s5_reg.xsq;
        s6_next.ysq = s5_reg.ysq;
        if (s5_reg.ctx.valid && !s5_reg.ctx.done) begin
            s6_next.ctx.count = cnt;
            s6_next.ctx.done  = (cnt >= max_iterations) || (len >= met_pkg::ESC_LIMIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.ctx.valid <= 1'b0;
            s2_reg.ctx.valid <= 1'b0;
            s3_reg.ctx.valid <= 1'b0;
            s4_reg.ctx.valid <= 1'b0;
            s5_reg.ctx.valid <= 1'b0;
            s6_reg.ctx.valid <= 1'b0;
        end else begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ins_seq_reg <= '0;
            ret_seq_reg <= '0;
        end else begin
            ins_seq_reg <= ins_seq_next;
            ret_seq_reg <= ret_seq_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mandelbrot_escape_time_top.sv */
// top level of the escape-time evaluator: configuration registers,
// coordinate mapper, iteration ring and output register; depends on met_pkg
`default_nettype none

// Each input word names a pixel; the block forms c from the origin and step
// registers (Q4.44), iterates z = z*z + c and returns the iteration count with
// the pixel's column and row. Each iteration makes one trip around a
// recirculating ring of six stages, so up to six pixels are worked on at once.
// A pixel enters the ring once its input word has passed the coordinate
// mapper and a ring slot is free; a limit of zero still costs one trip round
// the ring. Results leave in input order: a finished pixel keeps circulating
// until every older pixel has left, which can hold the ring back when a slow
// pixel precedes fast ones.

module mandelbrot_escape_time_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [47:0] cfg_wdata,
    // pixel input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // pixel_column[11:0], pixel_row[23:12]
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // escape_count[23:0], result_column[35:24],
                                        // result_row[47:36]
);

    // configuration registers
    logic [met_pkg::ITER_W-1:0] max_iter_reg;
    met_pkg::val_t              origin_re_reg, origin_im_reg;
    logic [met_pkg::STEP_W-1:0] step_re_reg, step_im_reg;

    // mapper to ring
    logic          ins_valid, ins_ready;
    met_pkg::ins_t ins_word;

    // ring to output register
    logic          ret_valid, ret_ready;
    met_pkg::ret_t ret_word;

    // output register
    logic          out_valid_reg;
    met_pkg::ret_t out_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg  <= met_pkg::MAX_ITER_RST;
            origin_re_reg <= met_pkg::ORIGIN_RST;
            origin_im_reg <= met_pkg::ORIGIN_RST;
            step_re_reg   <= met_pkg::STEP_RST;
            step_im_reg   <= met_pkg::STEP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                met_pkg::REG_MAX_ITER:  max_iter_reg  <= cfg_wdata[met_pkg::ITER_W-1:0];
                met_pkg::REG_ORIGIN_RE: origin_re_reg <= cfg_wdata;
                met_pkg::REG_ORIGIN_IM: origin_im_reg <= cfg_wdata;
                met_pkg::REG_STEP_RE:   step_re_reg   <= cfg_wdata[met_pkg::STEP_W-1:0];
                met_pkg::REG_STEP_IM:   step_im_reg   <= cfg_wdata[met_pkg::STEP_W-1:0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // c = origin + index * step, clamped and saturated
    met_coord u_coord (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_col    (s_tdata[11:0]),
        .in_row    (s_tdata[23:12]),
        .origin_re (origin_re_reg),
        .origin_im (origin_im_reg),
        .step_re   (step_re_reg),
        .step_im   (step_im_reg),
        .ins_valid (ins_valid),
        .ins_word  (ins_word),
        .ins_ready (ins_ready)
    );

    // the iteration ring itself
    met_iter_ring u_ring (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .max_iterations (max_iter_reg),
        .ins_valid      (ins_valid),
        .ins_word       (ins_word),
        .ins_ready      (ins_ready),
        .ret_valid      (ret_valid),
        .ret_word       (ret_word),
        .ret_ready      (ret_ready)
    );

    // output register parts the ring from the consumer
    assign ret_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ret_ready) begin
            out_valid_reg <= ret_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ret_ready && ret_valid) begin
            out_word_reg <= ret_word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_word_reg.row, out_word_reg.col, out_word_reg.count};

endmodule

`default_nettype wire
